>>> rtl/slj_pkg.sv
package slj_pkg;

    localparam int QuatFracBitsDefault = 14;
    localparam int NumRegs = 8;
    localparam int AddrW = 5;
    localparam int CordicSteps = 16;
    localparam int AngleMax = 25736;

    localparam logic [2:0] RegAx = 3'd0;
    localparam logic [2:0] RegAy = 3'd1;
    localparam logic [2:0] RegAz = 3'd2;
    localparam logic [2:0] RegBx = 3'd3;
    localparam logic [2:0] RegBy = 3'd4;
    localparam logic [2:0] RegBz = 3'd5;
    localparam logic [2:0] RegMax = 3'd6;
    localparam logic [2:0] RegGain = 3'd7;

    function automatic logic [19:0] atan_q16(input logic [3:0] i);
        logic [19:0] r;
        begin
            unique case (i)
                4'd0: r = 20'd51472;
                4'd1: r = 20'd30385;
                4'd2: r = 20'd16055;
                4'd3: r = 20'd8150;
                4'd4: r = 20'd4091;
                4'd5: r = 20'd2047;
                4'd6: r = 20'd1024;
                4'd7: r = 20'd512;
                4'd8: r = 20'd256;
                4'd9: r = 20'd128;
                4'd10: r = 20'd64;
                4'd11: r = 20'd32;
                4'd12: r = 20'd16;
                4'd13: r = 20'd8;
                4'd14: r = 20'd4;
                default: r = 20'd2;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        begin
            if (x > 64'sd32767) return 16'sd32767;
            else if (x < -64'sd32768) return -16'sd32768;
            else return x[15:0];
        end
    endfunction

endpackage

>>> rtl/swing_limit_jacobian_unit.sv
// Swing cone limit between two bones: takes both bone quaternions, rotates the configured local
// axes into world space, forms the hinge (cross product), the angle between the axes (dot
// product, integer square root, 16-step CORDIC arctangent) and the limit error and bias. One beat
// is accepted every cycle unless the pipeline is full and the output is stalled; the square-root
// stages yield one result bit each and the CORDIC stages one rotation each.
// Configuration registers are sampled as each beat passes and must only be written while idle.
module swing_limit_jacobian_unit #(
    parameter int QUAT_FRAC_BITS = slj_pkg::QuatFracBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [slj_pkg::AddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_quat_a_w,
    input  logic signed [15:0]  i_quat_a_x,
    input  logic signed [15:0]  i_quat_a_y,
    input  logic signed [15:0]  i_quat_a_z,
    input  logic signed [15:0]  i_quat_b_w,
    input  logic signed [15:0]  i_quat_b_x,
    input  logic signed [15:0]  i_quat_b_y,
    input  logic signed [15:0]  i_quat_b_z,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_hinge_x,
    output logic signed [15:0]  o_hinge_y,
    output logic signed [15:0]  o_hinge_z,
    output logic signed [17:0]  o_velocity_bias,
    output logic [14:0]         o_error_angle,
    output logic                o_has_error
);
    import slj_pkg::*;

    localparam int Q = QUAT_FRAC_BITS;
    localparam int SqW = 2 * Q + 2;
    localparam int SqSteps = Q + 1;
    localparam int NS = 10 + SqSteps + CordicSteps;
    localparam int ZW = 20;

    typedef struct packed {
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic signed [15:0] hz;
        logic [14:0]        max;
        logic [15:0]        gain;
    } t_side;

    logic signed [15:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [14:0] r_max;
    logic [15:0] r_gain;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= 16'sd16384; r_ay <= '0; r_az <= '0;
            r_bx <= 16'sd16384; r_by <= '0; r_bz <= '0;
            r_max <= '0; r_gain <= 16'd16384;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                RegAx: r_ax <= pwdata[15:0];
                RegAy: r_ay <= pwdata[15:0];
                RegAz: r_az <= pwdata[15:0];
                RegBx: r_bx <= pwdata[15:0];
                RegBy: r_by <= pwdata[15:0];
                RegBz: r_bz <= pwdata[15:0];
                RegMax: r_max <= pwdata[14:0];
                RegGain: r_gain <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            RegAx: prdata = {{16{r_ax[15]}}, r_ax};
            RegAy: prdata = {{16{r_ay[15]}}, r_ay};
            RegAz: prdata = {{16{r_az[15]}}, r_az};
            RegBx: prdata = {{16{r_bx[15]}}, r_bx};
            RegBy: prdata = {{16{r_by[15]}}, r_by};
            RegBz: prdata = {{16{r_bz[15]}}, r_bz};
            RegMax: prdata = {17'd0, r_max};
            RegGain: prdata = {16'd0, r_gain};
            default: prdata = '0;
        endcase
    end

    // Pipeline control: a stage advances when the stage after it is empty or advancing.
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] adv;
    always_comb begin
        adv[NS-1] = !r_v[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) adv[s] = !r_v[s] || adv[s+1];
    end
    assign o_ready = adv[0];
    assign o_valid = r_v[NS-1];

    always_comb begin
        n_v = r_v;
        if (adv[0]) n_v[0] = i_valid;
        for (int s = 1; s < NS; s++) if (adv[s]) n_v[s] = r_v[s-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else r_v <= n_v;
    end

    // Stage 0: t = 2*(qv x v) for each bone.
    logic signed [15:0] r0_qa [4], r0_qb [4];
    logic signed [34:0] r0_ta [3], r0_tb [3];
    logic signed [15:0] r0_va [3], r0_vb [3];
    t_side r0_sd;
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_qa[0] <= i_quat_a_w; r0_qa[1] <= i_quat_a_x;
            r0_qa[2] <= i_quat_a_y; r0_qa[3] <= i_quat_a_z;
            r0_qb[0] <= i_quat_b_w; r0_qb[1] <= i_quat_b_x;
            r0_qb[2] <= i_quat_b_y; r0_qb[3] <= i_quat_b_z;
            r0_va[0] <= r_ax; r0_va[1] <= r_ay; r0_va[2] <= r_az;
            r0_vb[0] <= r_bx; r0_vb[1] <= r_by; r0_vb[2] <= r_bz;
            r0_ta[0] <= 35'(2 * (i_quat_a_y * r_az - i_quat_a_z * r_ay));
            r0_ta[1] <= 35'(2 * (i_quat_a_z * r_ax - i_quat_a_x * r_az));
            r0_ta[2] <= 35'(2 * (i_quat_a_x * r_ay - i_quat_a_y * r_ax));
            r0_tb[0] <= 35'(2 * (i_quat_b_y * r_bz - i_quat_b_z * r_by));
            r0_tb[1] <= 35'(2 * (i_quat_b_z * r_bx - i_quat_b_x * r_bz));
            r0_tb[2] <= 35'(2 * (i_quat_b_x * r_by - i_quat_b_y * r_bx));
            r0_sd <= '{hx: '0, hy: '0, hz: '0, max: r_max, gain: r_gain};
        end
    end

    // Stage 1: the products of w*t + qv x t for each world axis component.
    logic signed [50:0] r1_pa [3][3], r1_pb [3][3];
    logic signed [15:0] r1_va [3], r1_vb [3];
    t_side r1_sd;
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_pa[0][0] <= r0_qa[0] * r0_ta[0];
            r1_pa[0][1] <= r0_qa[2] * r0_ta[2];
            r1_pa[0][2] <= r0_qa[3] * r0_ta[1];
            r1_pa[1][0] <= r0_qa[0] * r0_ta[1];
            r1_pa[1][1] <= r0_qa[3] * r0_ta[0];
            r1_pa[1][2] <= r0_qa[1] * r0_ta[2];
            r1_pa[2][0] <= r0_qa[0] * r0_ta[2];
            r1_pa[2][1] <= r0_qa[1] * r0_ta[1];
            r1_pa[2][2] <= r0_qa[2] * r0_ta[0];
            r1_pb[0][0] <= r0_qb[0] * r0_tb[0];
            r1_pb[0][1] <= r0_qb[2] * r0_tb[2];
            r1_pb[0][2] <= r0_qb[3] * r0_tb[1];
            r1_pb[1][0] <= r0_qb[0] * r0_tb[1];
            r1_pb[1][1] <= r0_qb[3] * r0_tb[0];
            r1_pb[1][2] <= r0_qb[1] * r0_tb[2];
            r1_pb[2][0] <= r0_qb[0] * r0_tb[2];
            r1_pb[2][1] <= r0_qb[1] * r0_tb[1];
            r1_pb[2][2] <= r0_qb[2] * r0_tb[0];
            r1_va <= r0_va;
            r1_vb <= r0_vb;
            r1_sd <= r0_sd;
        end
    end

    // Stage 2: s = w*t + qv x t, rounded once, world axis saturated.
    logic signed [15:0] r2_wa [3], r2_wb [3];
    t_side r2_sd;
    function automatic logic signed [15:0] rot_out(input logic signed [15:0] v,
                                                   input logic signed [63:0] s);
        logic signed [63:0] r;
        begin
            r = (s + (64'sd1 <<< (2 * Q - 1))) >>> (2 * Q);
            return sat16(64'(v) + r);
        end
    endfunction
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_wa[i] <= rot_out(r1_va[i], 64'(r1_pa[i][0]) + 64'(r1_pa[i][1])
                    - 64'(r1_pa[i][2]));
                r2_wb[i] <= rot_out(r1_vb[i], 64'(r1_pb[i][0]) + 64'(r1_pb[i][1])
                    - 64'(r1_pb[i][2]));
            end
            r2_sd <= r1_sd;
        end
    end

    // Stage 3: products for dot and cross.
    logic signed [31:0] r3_p [9];
    t_side r3_sd;
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_p[0] <= r2_wa[0] * r2_wb[0];
            r3_p[1] <= r2_wa[1] * r2_wb[1];
            r3_p[2] <= r2_wa[2] * r2_wb[2];
            r3_p[3] <= r2_wa[1] * r2_wb[2];
            r3_p[4] <= r2_wa[2] * r2_wb[1];
            r3_p[5] <= r2_wa[2] * r2_wb[0];
            r3_p[6] <= r2_wa[0] * r2_wb[2];
            r3_p[7] <= r2_wa[0] * r2_wb[1];
            r3_p[8] <= r2_wa[1] * r2_wb[0];
            r3_sd <= r2_sd;
        end
    end

    // Stage 4: rounded dot (clamped) and hinge.
    function automatic logic signed [63:0] rsh(input logic signed [63:0] x);
        begin
            return (x + (64'sd1 <<< (Q - 1))) >>> Q;
        end
    endfunction
    logic signed [Q+1:0] r4_d;
    t_side r4_sd;
    logic signed [63:0] dot_r;
    always_comb dot_r = rsh(64'(r3_p[0]) + 64'(r3_p[1]) + 64'(r3_p[2]));
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            if (dot_r > (64'sd1 <<< Q)) r4_d <= (Q+2)'(64'sd1 <<< Q);
            else if (dot_r < -(64'sd1 <<< Q)) r4_d <= (Q+2)'(-(64'sd1 <<< Q));
            else r4_d <= dot_r[Q+1:0];
            r4_sd <= '{hx: sat16(rsh(64'(r3_p[3]) - 64'(r3_p[4]))),
                       hy: sat16(rsh(64'(r3_p[5]) - 64'(r3_p[6]))),
                       hz: sat16(rsh(64'(r3_p[7]) - 64'(r3_p[8]))),
                       max: r3_sd.max, gain: r3_sd.gain};
        end
    end

    // Stage 5: radicand 2^(2Q) - d*d.
    logic signed [Q+1:0] r5_d;
    logic [SqW-1:0] r5_n;
    t_side r5_sd;
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_d <= r4_d;
            r5_n <= SqW'((64'sd1 <<< (2 * Q)) - 64'(r4_d * r4_d));
            r5_sd <= r4_sd;
        end
    end

    // Square root: one result bit per stage.
    logic [SqW-1:0] sq_n [SqSteps+1];
    logic [SqW-1:0] sq_r [SqSteps+1];
    logic signed [Q+1:0] sq_d [SqSteps+1];
    t_side sq_sd [SqSteps+1];
    assign sq_n[0] = r5_n;
    assign sq_r[0] = '0;
    assign sq_d[0] = r5_d;
    assign sq_sd[0] = r5_sd;
    for (genvar k = 0; k < SqSteps; k++) begin : g_sq
        localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (SqSteps - 1 - k));
        logic [SqW-1:0] r_n, r_r;
        logic signed [Q+1:0] r_d;
        t_side r_sd;
        always_ff @(posedge i_clk) begin
            if (adv[6+k]) begin
                if (sq_n[k] >= sq_r[k] + Bit) begin
                    r_n <= sq_n[k] - (sq_r[k] + Bit);
                    r_r <= (sq_r[k] >> 1) + Bit;
                end else begin
                    r_n <= sq_n[k];
                    r_r <= sq_r[k] >> 1;
                end
                r_d <= sq_d[k];
                r_sd <= sq_sd[k];
            end
        end
        assign sq_n[k+1] = r_n;
        assign sq_r[k+1] = r_r;
        assign sq_d[k+1] = r_d;
        assign sq_sd[k+1] = r_sd;
    end

    // Pre-rotation by pi/2 for a negative cosine.
    localparam int CW = Q + 4;
    logic signed [CW-1:0] r6_x, r6_y;
    logic signed [ZW-1:0] r6_z;
    t_side r6_sd;
    always_ff @(posedge i_clk) begin
        if (adv[6+SqSteps]) begin
            if (sq_d[SqSteps] < 0) begin
                r6_x <= CW'(sq_r[SqSteps]);
                r6_y <= -CW'(sq_d[SqSteps]);
                r6_z <= ZW'(102944);
            end else begin
                r6_x <= CW'(sq_d[SqSteps]);
                r6_y <= CW'(sq_r[SqSteps]);
                r6_z <= '0;
            end
            r6_sd <= sq_sd[SqSteps];
        end
    end

    logic signed [CW-1:0] cx [CordicSteps+1], cy [CordicSteps+1];
    logic signed [ZW-1:0] cz [CordicSteps+1];
    t_side csd [CordicSteps+1];
    assign cx[0] = r6_x;
    assign cy[0] = r6_y;
    assign cz[0] = r6_z;
    assign csd[0] = r6_sd;
    for (genvar k = 0; k < CordicSteps; k++) begin : g_cor
        logic signed [CW-1:0] r_x, r_y;
        logic signed [ZW-1:0] r_z;
        t_side r_sd;
        always_ff @(posedge i_clk) begin
            if (adv[7+SqSteps+k]) begin
                if (cy[k] >= 0) begin
                    r_x <= cx[k] + (cy[k] >>> k);
                    r_y <= cy[k] - (cx[k] >>> k);
                    r_z <= cz[k] + ZW'(atan_q16(4'(k)));
                end else begin
                    r_x <= cx[k] - (cy[k] >>> k);
                    r_y <= cy[k] + (cx[k] >>> k);
                    r_z <= cz[k] - ZW'(atan_q16(4'(k)));
                end
                r_sd <= csd[k];
            end
        end
        assign cx[k+1] = r_x;
        assign cy[k+1] = r_y;
        assign cz[k+1] = r_z;
        assign csd[k+1] = r_sd;
    end

    // Angle, then error and bias product.
    localparam int SE = 7 + SqSteps + CordicSteps;
    logic signed [ZW-1:0] ang_r;
    logic [14:0] ang;
    always_comb begin
        ang_r = (cz[CordicSteps] + ZW'(4)) >>> 3;
        if (ang_r < 0) ang = '0;
        else if (ang_r > ZW'(AngleMax)) ang = 15'(AngleMax);
        else ang = ang_r[14:0];
    end
    logic [14:0] r7_ang;
    t_side r7_sd;
    always_ff @(posedge i_clk) begin
        if (adv[SE]) begin
            r7_ang <= ang;
            r7_sd <= csd[CordicSteps];
        end
    end

    logic [14:0] r8_err;
    logic signed [17:0] r8_neg;
    logic r8_over;
    logic [30:0] r8_prod;
    t_side r8_sd;
    always_ff @(posedge i_clk) begin
        if (adv[SE+1]) begin
            r8_over <= r7_ang >= r7_sd.max;
            r8_err <= (r7_ang >= r7_sd.max) ? r7_ang - r7_sd.max : '0;
            r8_neg <= 18'(signed'({1'b0, r7_ang}) - signed'({1'b0, r7_sd.max}));
            r8_prod <= 31'(r7_sd.gain * ((r7_ang >= r7_sd.max)
                ? r7_ang - r7_sd.max : 15'd0));
            r8_sd <= r7_sd;
        end
    end

    logic [30:0] br;
    assign br = (r8_prod + 31'd8192) >> 14;
    always_ff @(posedge i_clk) begin
        if (adv[SE+2]) begin
            o_hinge_x <= r8_sd.hx;
            o_hinge_y <= r8_sd.hy;
            o_hinge_z <= r8_sd.hz;
            o_error_angle <= r8_err;
            o_has_error <= r8_err != '0;
            if (!r8_over) o_velocity_bias <= r8_neg;
            else if (br > 31'd131071) o_velocity_bias <= 18'sd131071;
            else o_velocity_bias <= br[17:0];
        end
    end

    a_err_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_has_error == (o_error_angle != '0)))
        else $error("has_error disagrees with error_angle");
    a_bias_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_error) |-> !o_velocity_bias[17])
        else $error("negative bias with an error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_error_angle)))
        else $error("stalled result changed");

endmodule
